### hw/rtl/memory_region_table_defines.svh
// ---------------------------------------------------------------------------
// memory_region_table_defines.svh
// Assertion macros used by the memory region table datapath.
// ---------------------------------------------------------------------------
`ifndef MEMORY_REGION_TABLE_DEFINES_SVH
`define MEMORY_REGION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define MRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Plain expression that must be true at every clock edge outside reset.
`define MRT_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

`else

`define MRT_ASSERT(lbl, clk, rstn, prop, msg)
`define MRT_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)

`endif

`endif

### hw/rtl/mrt_pkg.sv
// ---------------------------------------------------------------------------
// mrt_pkg
// Types and codes shared by the memory region table controller and datapath.
// ---------------------------------------------------------------------------
package mrt_pkg;

  typedef enum logic [2:0] {
    CMD_MAP     = 3'd0,
    CMD_UNMAP   = 3'd1,
    CMD_PROTECT = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_FAULT   = 3'd4
  } cmd_e;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic [2:0] RS_DECLARED  = 3'd1;
  localparam logic [2:0] RS_VALIDATED = 3'd2;
  localparam logic [2:0] RS_ACTIVE    = 3'd3;
  localparam logic [2:0] RS_REVOKED   = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] space;
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] flags;
    logic [2:0]  state;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture request, restart scan at entry 0
    logic step;      // advance scan index
    logic hit_cap;   // register result for a matching entry
    logic miss_cap;  // register result for scan exhausted / bad command
    logic update;    // write back the matched entry
  } dp_ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;        // current entry matches the command
    logic miss_done;  // no match and nothing left to scan, or unknown command
    logic wr_req;     // command modifies the entry it matches
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

endpackage

### hw/rtl/mrt_ctrl.sv
// ---------------------------------------------------------------------------
// mrt_ctrl
// Sequencer for the region table: accept, scan, optional write-back, respond.
// ---------------------------------------------------------------------------
module mrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mrt_pkg::dp_stat_t stat_i,
  output mrt_pkg::dp_ctl_t  ctl_o
);

  mrt_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      mrt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = mrt_pkg::ST_SCAN;
        end
      end
      mrt_pkg::ST_SCAN: begin
        if (stat_i.hit) begin
          ctl_o.hit_cap = 1'b1;
          state_d       = stat_i.wr_req ? mrt_pkg::ST_UPDATE : mrt_pkg::ST_RESP;
        end else if (stat_i.miss_done) begin
          ctl_o.miss_cap = 1'b1;
          state_d        = mrt_pkg::ST_RESP;
        end else begin
          ctl_o.step = 1'b1;
        end
      end
      mrt_pkg::ST_UPDATE: begin
        ctl_o.update = 1'b1;
        state_d      = mrt_pkg::ST_RESP;
      end
      mrt_pkg::ST_RESP: begin
        if (!out_stall_i) begin
          state_d = mrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != mrt_pkg::ST_IDLE);
  assign out_valid_o = (state_q == mrt_pkg::ST_RESP);

endmodule

### hw/rtl/mrt_datapath.sv
// ---------------------------------------------------------------------------
// mrt_datapath
// Entry storage, scan index, match logic, id counter and result register.
// ---------------------------------------------------------------------------
`include "memory_region_table_defines.svh"

module mrt_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrt_pkg::dp_ctl_t  ctl_i,
  output mrt_pkg::dp_stat_t stat_o,
  input  logic [2:0]        cmd_i,
  input  logic [31:0]       space_id_i,
  input  logic [63:0]       base_addr_i,
  input  logic [63:0]       region_len_i,
  input  logic [31:0]       map_flags_i,
  input  logic [31:0]       target_id_i,
  input  logic [31:0]       prot_flags_i,
  input  logic [63:0]       fault_addr_i,
  output logic [1:0]        status_o,
  output logic [31:0]       out_id_o,
  output logic [2:0]        out_state_o,
  output logic [63:0]       out_base_o,
  output logic [63:0]       out_len_o,
  output logic              fault_kill_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Captured request
  mrt_pkg::cmd_e cmd_q;
  logic [31:0]   space_q;
  logic [63:0]   base_q;
  logic [63:0]   len_q;
  logic [31:0]   mflags_q;
  logic [31:0]   tid_q;
  logic [31:0]   pflags_q;
  logic [63:0]   faddr_q;

  // Table state
  mrt_pkg::entry_t        mem [TABLE_DEPTH];
  mrt_pkg::entry_t        rd_q;
  logic [TABLE_DEPTH-1:0] used_q;
  logic [TABLE_DEPTH-1:0] written_q;  // entry has been mapped at least once
  logic [31:0]            id_cnt_q;
  logic [IdxW-1:0]        idx_q, idx_d;

  mrt_pkg::entry_t cur;
  mrt_pkg::entry_t wr_word;
  logic [63:0]     end_addr;
  logic            last;
  logic            known;
  logic            match;

  // Result register
  logic [1:0]  status_q;
  logic [31:0] out_id_q;
  logic [2:0]  out_state_q;
  logic [63:0] out_base_q;
  logic [63:0] out_len_q;
  logic        kill_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= mrt_pkg::cmd_e'(cmd_i);
      space_q  <= space_id_i;
      base_q   <= base_addr_i;
      len_q    <= region_len_i;
      mflags_q <= map_flags_i;
      tid_q    <= target_id_i;
      pflags_q <= prot_flags_i;
      faddr_q  <= fault_addr_i;
    end
  end

  // Read address runs one step ahead so rd_q holds entry idx_q during the scan.
  always_comb begin
    idx_d = idx_q;
    if (ctl_i.load) begin
      idx_d = '0;
    end else if (ctl_i.step) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update) begin
      mem[idx_q] <= wr_word;
    end
    rd_q <= mem[idx_d];
  end

  // Never-mapped entries read as all zero.
  assign cur      = written_q[idx_q] ? rd_q : '0;
  assign end_addr = cur.base + cur.len;
  assign last     = (idx_q == IdxW'(TABLE_DEPTH - 1));

  always_comb begin
    known = 1'b1;
    match = 1'b0;
    unique case (cmd_q)
      mrt_pkg::CMD_MAP:     match = !used_q[idx_q];
      mrt_pkg::CMD_UNMAP,
      mrt_pkg::CMD_PROTECT: match = used_q[idx_q] && (cur.id == tid_q);
      mrt_pkg::CMD_QUERY:   match = (tid_q != 32'd0) && (cur.id == tid_q);
      mrt_pkg::CMD_FAULT:   match = used_q[idx_q] && (cur.space == space_q) &&
                                    (faddr_q >= cur.base) && (faddr_q < end_addr);
      default:              known = 1'b0;
    endcase
  end

  assign stat_o.hit       = match;
  assign stat_o.miss_done = !match && (last || !known);
  assign stat_o.wr_req    = (cmd_q != mrt_pkg::CMD_QUERY);

  always_comb begin
    wr_word = cur;
    unique case (cmd_q)
      mrt_pkg::CMD_MAP: begin
        wr_word.id    = id_cnt_q;
        wr_word.space = space_q;
        wr_word.base  = base_q;
        wr_word.len   = len_q;
        wr_word.flags = mflags_q;
        wr_word.state = mrt_pkg::RS_DECLARED;
      end
      mrt_pkg::CMD_UNMAP:   wr_word.state = mrt_pkg::RS_REVOKED;
      mrt_pkg::CMD_PROTECT: begin
        wr_word.flags = pflags_q;
        wr_word.state = mrt_pkg::RS_VALIDATED;
      end
      mrt_pkg::CMD_FAULT:   wr_word.state = mrt_pkg::RS_ACTIVE;
      default:              wr_word = cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      used_q    <= '0;
      written_q <= '0;
      id_cnt_q  <= 32'd1;
    end else begin
      idx_q <= idx_d;
      if (ctl_i.update) begin
        if (cmd_q == mrt_pkg::CMD_MAP) begin
          used_q[idx_q]    <= 1'b1;
          written_q[idx_q] <= 1'b1;
          id_cnt_q         <= id_cnt_q + 32'd1;
        end else if (cmd_q == mrt_pkg::CMD_UNMAP) begin
          used_q[idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hit_cap) begin
      status_q    <= mrt_pkg::STATUS_OK;
      out_id_q    <= '0;
      out_state_q <= '0;
      out_base_q  <= '0;
      out_len_q   <= '0;
      kill_q      <= 1'b0;
      if (cmd_q == mrt_pkg::CMD_MAP) begin
        out_id_q <= id_cnt_q;
      end else if (cmd_q == mrt_pkg::CMD_QUERY) begin
        out_id_q    <= cur.id;
        out_state_q <= cur.state;
        out_base_q  <= cur.base;
        out_len_q   <= cur.len;
      end
    end else if (ctl_i.miss_cap) begin
      status_q    <= (cmd_q == mrt_pkg::CMD_MAP) ? mrt_pkg::STATUS_FULL
                                                 : mrt_pkg::STATUS_NOT_FOUND;
      out_id_q    <= '0;
      out_state_q <= '0;
      out_base_q  <= '0;
      out_len_q   <= '0;
      kill_q      <= (cmd_q == mrt_pkg::CMD_FAULT);
    end
  end

  assign status_o     = status_q;
  assign out_id_o     = out_id_q;
  assign out_state_o  = out_state_q;
  assign out_base_o   = out_base_q;
  assign out_len_o    = out_len_q;
  assign fault_kill_o = kill_q;

  `MRT_ASSERT_ALWAYS(a_used_implies_written, clk_i, rst_ni, (used_q & ~written_q) == '0, "live entry never written")
  `MRT_ASSERT(a_map_takes_free, clk_i, rst_ni, ctl_i.update && (cmd_q == mrt_pkg::CMD_MAP) |-> !used_q[idx_q], "map overwrote a live entry")
  `MRT_ASSERT(a_map_bumps_id, clk_i, rst_ni, ctl_i.update && (cmd_q == mrt_pkg::CMD_MAP) |=> id_cnt_q == $past(id_cnt_q) + 32'd1, "id counter did not advance on map")

endmodule

### hw/rtl/memory_region_table.sv
// A request is taken only while idle; the scan then checks one entry per cycle
// from entry 0 until a hit, the last entry or an unknown command, and a hit for
// map, unmap, protect or fault passes through the write-back state before the
// result is valid. The next request is taken the cycle after the result transfer.
// Reset: table reads as empty at once (per-entry used/written flags cleared),
// id counter returns to one; no clearing pass.
// ---------------------------------------------------------------------------
// memory_region_table
// Region table with map, unmap, protect, query and fault lookup commands.
// ---------------------------------------------------------------------------
module memory_region_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] space_id_i,
  input  logic [63:0] base_addr_i,
  input  logic [63:0] region_len_i,
  input  logic [31:0] map_flags_i,
  input  logic [31:0] target_id_i,
  input  logic [31:0] prot_flags_i,
  input  logic [63:0] fault_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_id_o,
  output logic [2:0]  out_state_o,
  output logic [63:0] out_base_o,
  output logic [63:0] out_len_o,
  output logic        fault_kill_o
);

  mrt_pkg::dp_ctl_t  ctl;
  mrt_pkg::dp_stat_t stat;

  mrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  mrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cmd_i        (cmd_i),
    .space_id_i   (space_id_i),
    .base_addr_i  (base_addr_i),
    .region_len_i (region_len_i),
    .map_flags_i  (map_flags_i),
    .target_id_i  (target_id_i),
    .prot_flags_i (prot_flags_i),
    .fault_addr_i (fault_addr_i),
    .status_o     (status_o),
    .out_id_o     (out_id_o),
    .out_state_o  (out_state_o),
    .out_base_o   (out_base_o),
    .out_len_o    (out_len_o),
    .fault_kill_o (fault_kill_o)
  );

endmodule

### sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for memory_region_table. A behavioral copy of the
// region table predicts every response; directed cases cover the field
// extremes, each command, wrapped and empty fault ranges and unknown opcodes.
// Random map/unmap/protect/query/fault and bad-opcode traffic follows, with
// random sender gaps, receiver stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;

  localparam int TABLE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int SEGMENT_ITEMS = 60;
  localparam int STUCK_LIMIT   = 1000;
  localparam int PRESSURE_HOLD = 300;

  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] space;
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] mflags;
    logic [31:0] tid;
    logic [31:0] pflags;
    logic [63:0] faddr;
  } region_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [2:0]  state;
    logic [63:0] base;
    logic [63:0] len;
    logic        kill;
  } region_rsp_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [2:0]  cmd        = '0;
  logic [31:0] space_id   = '0;
  logic [63:0] base_addr  = '0;
  logic [63:0] region_len = '0;
  logic [31:0] map_flags  = '0;
  logic [31:0] target_id  = '0;
  logic [31:0] prot_flags = '0;
  logic [63:0] fault_addr = '0;
  logic        out_stall  = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] out_id;
  logic [2:0]  out_state;
  logic [63:0] out_base;
  logic [63:0] out_len;
  logic        fault_kill;

  // Predicted table contents
  mrt_pkg::entry_t region_tab  [TABLE_DEPTH];
  bit              region_live [TABLE_DEPTH];
  logic [31:0]     model_next_id;

  region_rsp_t pending_rsps[$];
  int unsigned error_count   = 0;
  bit          quiet_mode    = 1'b0;
  int unsigned hold_request  = 0;
  int unsigned stuck_cycles  = 0;

  memory_region_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .space_id_i  (space_id),
    .base_addr_i (base_addr),
    .region_len_i(region_len),
    .map_flags_i (map_flags),
    .target_id_i (target_id),
    .prot_flags_i(prot_flags),
    .fault_addr_i(fault_addr),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .out_id_o    (out_id),
    .out_state_o (out_state),
    .out_base_o  (out_base),
    .out_len_o   (out_len),
    .fault_kill_o(fault_kill)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the predicted table and return the response it gives.
  function automatic region_rsp_t table_apply(region_req_t r);
    region_rsp_t rsp;
    logic [63:0] range_end;
    int slot;
    rsp = '0;
    rsp.status = mrt_pkg::STATUS_NOT_FOUND;
    slot = -1;
    case (r.cmd)
      mrt_pkg::CMD_MAP: begin
        rsp.status = mrt_pkg::STATUS_FULL;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot < 0 && !region_live[i]) slot = i;
        if (slot >= 0) begin
          region_live[slot] = 1'b1;
          region_tab[slot] = '{id: model_next_id, space: r.space, base: r.base,
                               len: r.len, flags: r.mflags,
                               state: mrt_pkg::RS_DECLARED};
          rsp.status = mrt_pkg::STATUS_OK;
          rsp.id = model_next_id;
          model_next_id++;
        end
      end
      mrt_pkg::CMD_UNMAP, mrt_pkg::CMD_PROTECT: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot < 0 && region_live[i] && region_tab[i].id == r.tid) slot = i;
        if (slot >= 0) begin
          rsp.status = mrt_pkg::STATUS_OK;
          if (r.cmd == mrt_pkg::CMD_UNMAP) begin
            region_live[slot] = 1'b0;
            region_tab[slot].state = mrt_pkg::RS_REVOKED;
          end else begin
            region_tab[slot].flags = r.pflags;
            region_tab[slot].state = mrt_pkg::RS_VALIDATED;
          end
        end
      end
      mrt_pkg::CMD_QUERY: begin
        // id zero never matches: unwritten entries carry it
        if (r.tid != '0) begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && region_tab[i].id == r.tid) slot = i;
          if (slot >= 0) begin
            rsp.status = mrt_pkg::STATUS_OK;
            rsp.id = region_tab[slot].id;
            rsp.state = region_tab[slot].state;
            rsp.base = region_tab[slot].base;
            rsp.len = region_tab[slot].len;
          end
        end
      end
      mrt_pkg::CMD_FAULT: begin
        rsp.kill = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          range_end = region_tab[i].base + region_tab[i].len;  // wraps at 64 bits
          if (slot < 0 && region_live[i] && region_tab[i].space == r.space &&
              r.faddr >= region_tab[i].base && r.faddr < range_end) slot = i;
        end
        if (slot >= 0) begin
          region_tab[slot].state = mrt_pkg::RS_ACTIVE;
          rsp.kill = 1'b0;
          rsp.status = mrt_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random live slot, or -1 when the table is empty.
  function automatic int live_index();
    int slots[$];
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (region_live[i]) slots.push_back(i);
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(0, slots.size() - 1)];
  endfunction

  // Mostly live ids, some freed ones, some arbitrary values.
  function automatic logic [31:0] random_target();
    logic [31:0] ids[$];
    int unsigned pick;
    bit live_only;
    pick = $urandom_range(0, 99);
    if (pick >= 85) return $urandom;
    live_only = pick < 70;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (region_tab[i].id != '0 && (region_live[i] || !live_only))
        ids.push_back(region_tab[i].id);
    if (ids.size() == 0) return $urandom;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic region_req_t random_request();
    region_req_t r;
    int unsigned pick;
    int slot;
    r.space  = $urandom;
    r.base   = rand64();
    r.len    = rand64();
    r.mflags = $urandom;
    r.tid    = $urandom;
    r.pflags = $urandom;
    r.faddr  = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      r.cmd = mrt_pkg::CMD_MAP;
      if ($urandom_range(0, 4) != 0) r.space = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: r.len = '0;
        1, 2: ;
        default: r.len = $urandom_range(1, 4096);
      endcase
      // overlap an existing region so the lowest-entry rule gets exercised
      slot = live_index();
      if (slot >= 0 && $urandom_range(0, 3) == 0) begin
        r.space = region_tab[slot].space;
        r.base = region_tab[slot].base + $urandom_range(0, 64);
      end
    end else if (pick < 47) begin
      r.cmd = mrt_pkg::CMD_UNMAP;
      r.tid = random_target();
    end else if (pick < 60) begin
      r.cmd = mrt_pkg::CMD_PROTECT;
      r.tid = random_target();
    end else if (pick < 75) begin
      r.cmd = mrt_pkg::CMD_QUERY;
      r.tid = ($urandom_range(0, 19) == 0) ? '0 : random_target();
    end else if (pick < 96) begin
      r.cmd = mrt_pkg::CMD_FAULT;
      slot = live_index();
      if (slot >= 0 && $urandom_range(0, 4) != 0) begin
        r.space = region_tab[slot].space;
        case ($urandom_range(0, 5))
          0: r.faddr = region_tab[slot].base + region_tab[slot].len;
          1: r.faddr = region_tab[slot].base - 1;
          default: begin
            r.faddr = region_tab[slot].base;
            if (region_tab[slot].len != '0)
              r.faddr = region_tab[slot].base + rand64() % region_tab[slot].len;
          end
        endcase
      end else if ($urandom_range(0, 4) != 0) begin
        r.space = $urandom_range(0, 3);
      end
    end else begin
      r.cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    end
    return r;
  endfunction

  // Offer one request and wait for its transfer; valid stays high for the next
  // call unless that call draws a gap.
  task automatic issue_request(input region_req_t r);
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= r.cmd;
    space_id   <= r.space;
    base_addr  <= r.base;
    region_len <= r.len;
    map_flags  <= r.mflags;
    target_id  <= r.tid;
    prot_flags <= r.pflags;
    fault_addr <= r.faddr;
    do @(posedge clk); while (in_stall);
    pending_rsps.push_back(table_apply(r));
  endtask

  task automatic send_map(input logic [31:0] space, input logic [63:0] base,
                          input logic [63:0] len, input logic [31:0] flags);
    region_req_t r;
    r = '0;
    r.cmd = mrt_pkg::CMD_MAP;
    r.space = space;
    r.base = base;
    r.len = len;
    r.mflags = flags;
    issue_request(r);
  endtask

  task automatic send_by_id(input logic [2:0] op, input logic [31:0] tid,
                            input logic [31:0] pflags = '0);
    region_req_t r;
    r = '0;
    r.cmd = op;
    r.tid = tid;
    r.pflags = pflags;
    issue_request(r);
  endtask

  task automatic send_fault(input logic [31:0] space, input logic [63:0] addr);
    region_req_t r;
    r = '0;
    r.cmd = mrt_pkg::CMD_FAULT;
    r.space = space;
    r.faddr = addr;
    issue_request(r);
  endtask

  task automatic test_empty_table();
    send_by_id(mrt_pkg::CMD_QUERY, '0);
    send_by_id(mrt_pkg::CMD_QUERY, 32'd1);
    send_by_id(mrt_pkg::CMD_UNMAP, 32'd1);
    send_by_id(mrt_pkg::CMD_PROTECT, 32'd1, '1);
    send_fault('0, '0);
  endtask

  task automatic test_map_extremes();
    send_map('0, '0, '0, '0);
    send_map('1, '1, '1, '1);
    send_by_id(mrt_pkg::CMD_QUERY, 32'd1);
    send_by_id(mrt_pkg::CMD_QUERY, 32'd2);
    send_fault('0, '0);   // zero length: nothing covered
    send_fault('1, '1);   // end wraps below base: empty range
  endtask

  task automatic test_protect_and_fault();
    send_map(32'h5, 64'h1000, 64'h100, 32'h0000_00ff);
    send_by_id(mrt_pkg::CMD_PROTECT, 32'd3, 32'hffff_ff00);
    send_by_id(mrt_pkg::CMD_QUERY, 32'd3);
    send_fault(32'h5, 64'h1000);
    send_fault(32'h5, 64'h10ff);
    send_fault(32'h5, 64'h1100);
    send_fault(32'h5, 64'h0fff);
    send_fault(32'h6, 64'h1000);
    send_by_id(mrt_pkg::CMD_QUERY, 32'd3);
  endtask

  task automatic test_unmap();
    send_by_id(mrt_pkg::CMD_UNMAP, 32'd3);
    send_by_id(mrt_pkg::CMD_QUERY, 32'd3);
    send_by_id(mrt_pkg::CMD_UNMAP, 32'd3);
    send_fault(32'h5, 64'h1000);
  endtask

  task automatic test_unknown_cmds();
    region_req_t r;
    r = '1;
    for (int c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++) begin
      r.cmd = 3'(c);
      issue_request(r);
    end
  endtask

  // Long receiver hold-off while requests keep coming back to back.
  task automatic test_backpressure();
    hold_request = PRESSURE_HOLD;
    quiet_mode = 1'b1;
    repeat (12) issue_request(random_request());
    quiet_mode = 1'b0;
  endtask

  task automatic test_random();
    for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT_ITEMS; seg++) begin
      quiet_mode = ($urandom_range(0, 3) == 0);
      repeat (SEGMENT_ITEMS) issue_request(random_request());
    end
    quiet_mode = 1'b0;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  initial begin : result_checker
    int unsigned hold;
    region_rsp_t want;
    wait (rst_n);
    forever begin
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end else begin
        hold = quiet_mode ? 0 : $urandom_range(0, 15);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (pending_rsps.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        want = pending_rsps.pop_front();
        check_field("status", want.status, status);
        check_field("out_id", want.id, out_id);
        check_field("out_state", want.state, out_state);
        check_field("out_base", want.base, out_base);
        check_field("out_len", want.len, out_len);
        check_field("fault_kill", want.kill, fault_kill);
      end
    end
  end

  // Cycles without any transfer on either side
  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      region_tab[i] = '0;
      region_live[i] = 1'b0;
    end
    model_next_id = 32'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_map_extremes();
    test_protect_and_fault();
    test_unmap();
    test_unknown_cmds();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mrt_pkg.sv
hw/rtl/mrt_ctrl.sv
hw/rtl/mrt_datapath.sv
hw/rtl/memory_region_table.sv
sim/testbench.sv
